@@ hdl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg: shared definitions for the block bitmap allocator
// Field widths, status codes, controller/datapath command and status
// structs, and the first-set-bit search used by the scan.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int BLK_W          = 12;   // block number width
	localparam int BIT_W          = 6;    // bit position inside a bitmap word
	localparam int WORD_W         = 64;   // bitmap word width
	localparam int TOTAL_W        = 13;   // total_blocks register width
	localparam int WCNT_W         = 7;    // word count, up to 64
	localparam int STAT_W         = 2;
	localparam int OUT_CAP        = 4096; // largest grantable range
	localparam int MAX_BLOCKS_DEF = 4096;

	localparam logic [TOTAL_W-1:0] TOTAL_RST = 13'd4096;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL        = 2'd1;
	localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE       = 2'd3;

	typedef struct packed {
		logic accept;     // request transaction taken this cycle
		logic scan_step;  // read next word, check the word read last cycle
		logic free_chk;   // check and clear the bit of a free request
		logic push;       // move the result into the output register
		logic clr_step;   // clear one bitmap word after reset
	} cmd_t;

	typedef struct packed {
		logic imm_done;   // incoming request resolves without the bitmap
		logic in_free;    // incoming request is a free
		logic scan_done;  // scan found a free block or ran out of words
		logic clr_last;   // clearing the last word
		logic out_busy;   // output register holds a result not yet taken
	} sts_t;

	// Lowest set bit of a 64-bit word: pick the first nonempty byte, then
	// the first set bit inside it.
	function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] v);
		logic [7:0] g_any;
		logic [2:0] g;
		logic [7:0] gv;
		logic [2:0] b;
		for (int i = 0; i < 8; i++) begin
			g_any[i] = |v[8*i +: 8];
		end
		g = '0;
		for (int i = 7; i >= 0; i--) begin
			if (g_any[i]) g = 3'(i);
		end
		gv = v[8*g +: 8];
		b = '0;
		for (int i = 7; i >= 0; i--) begin
			if (gv[i]) b = 3'(i);
		end
		return {g, b};
	endfunction

endpackage

@@ hdl/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl: sequencer of the block bitmap allocator
// Runs the clearing pass after reset, takes one request at a time and
// steps the datapath through the scan or the free check.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bba_pkg::sts_t  sts,
	output bba_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_FREE  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (sts.imm_done) begin
						state_d = S_DONE;
					end else if (sts.in_free) begin
						state_d = S_FREE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = S_DONE;
			end
			S_FREE: begin
				cmd.free_chk = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

@@ hdl/bba_dp.sv @@
// ----------------------------------------------------------------------------
// bba_dp: datapath of the block bitmap allocator
// Usage bitmap memory of 64-bit words, the limit logic, the word scan with
// first-free search, the free check and the output register.
// ----------------------------------------------------------------------------
module bba_dp #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bba_pkg::TOTAL_W-1:0] cfg_data,
	input  logic                        action,
	input  logic [bba_pkg::BLK_W-1:0]   block_number,
	input  logic                        rsp_stall,
	output logic                        rsp_valid,
	output logic [bba_pkg::BLK_W-1:0]   allocated_block,
	output logic [bba_pkg::STAT_W-1:0]  status,
	input  bba_pkg::cmd_t               cmd,
	output bba_pkg::sts_t               sts
);

	localparam int TW    = bba_pkg::TOTAL_W;
	localparam int BW    = bba_pkg::BLK_W;
	localparam int IW    = bba_pkg::BIT_W;
	localparam int WW    = bba_pkg::WORD_W;
	localparam int CW    = bba_pkg::WCNT_W;
	localparam int SW    = bba_pkg::STAT_W;
	localparam int WDW   = BW - IW;
	localparam int CAP_BLOCKS = (MAX_BLOCKS < bba_pkg::OUT_CAP) ? MAX_BLOCKS : bba_pkg::OUT_CAP;
	localparam int NWORDS     = (CAP_BLOCKS + WW - 1) / WW;
	localparam int AW         = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam logic [TW-1:0] CAP_LIM   = TW'(CAP_BLOCKS);
	localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

	logic [WW-1:0] mem [NWORDS];

	logic [TW-1:0] total_q, lim, lim_rnd;
	logic [CW-1:0] nwords, nw_m1;
	logic [AW-1:0] clr_ptr_q, rd_ptr_q, raddr, addr_s1, in_word, blk_word;
	logic [WW-1:0] rdata_s1, vmask, free_vec, wdata;
	logic          rvld_s1, word_full, word_edge, any_free, last_chk;
	logic [IW-1:0] free_idx;
	logic          found_we, free_we, free_bit, we;
	logic [AW-1:0] waddr;
	logic [BW-1:0] blk_q, res_blk_q, out_blk_q;
	logic [SW-1:0] res_st_q, out_st_q;
	logic          rsp_valid_q;

	// effective limit: register saturated to the storage and to 4096
	assign lim     = (total_q > CAP_LIM) ? CAP_LIM : total_q;
	assign lim_rnd = lim + TW'(WW - 1);
	assign nwords  = lim_rnd[TW-1:IW];
	assign nw_m1   = nwords - CW'(1);

	assign in_word  = block_number[IW +: AW];
	assign blk_word = blk_q[IW +: AW];
	assign raddr    = cmd.scan_step ? rd_ptr_q : in_word;

	// bits of the checked word that lie below the limit
	assign word_full = CW'(addr_s1) < lim[TW-1:IW];
	assign word_edge = CW'(addr_s1) == lim[TW-1:IW];
	always_comb begin
		for (int b = 0; b < WW; b++) begin
			vmask[b] = word_full || (word_edge && (IW'(b) < lim[IW-1:0]));
		end
	end

	assign free_vec = ~rdata_s1 & vmask;
	assign any_free = |free_vec;
	assign free_idx = bba_pkg::first_one(free_vec);
	assign last_chk = (addr_s1 == nw_m1[AW-1:0]);

	assign found_we = cmd.scan_step && rvld_s1 && any_free;
	assign free_bit = rdata_s1[blk_q[IW-1:0]];
	assign free_we  = cmd.free_chk && free_bit;

	always_comb begin
		we    = 1'b0;
		waddr = clr_ptr_q;
		wdata = '0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (found_we) begin
			we    = 1'b1;
			waddr = addr_s1;
			wdata = rdata_s1 | (WW'(1) << free_idx);
		end else if (free_we) begin
			we    = 1'b1;
			waddr = blk_word;
			wdata = rdata_s1 & ~(WW'(1) << blk_q[IW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_s1 <= mem[raddr];
		addr_s1  <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= bba_pkg::TOTAL_RST;
			clr_ptr_q   <= '0;
			rd_ptr_q    <= '0;
			rvld_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) total_q <= cfg_data;
			if (cmd.clr_step) clr_ptr_q <= clr_ptr_q + AW'(1);
			if (cmd.accept) begin
				rd_ptr_q <= '0;
			end else if (cmd.scan_step) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			// read data of a scan word lands in the cycle after its address
			rvld_s1 <= cmd.scan_step;
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) blk_q <= block_number;
		if (cmd.accept) begin
			res_blk_q <= '0;
			res_st_q  <= (action == bba_pkg::ACT_FREE) ? bba_pkg::ST_RANGE : bba_pkg::ST_FULL;
		end else if (cmd.scan_step && rvld_s1) begin
			if (any_free) begin
				res_blk_q <= {WDW'(addr_s1), free_idx};
				res_st_q  <= bba_pkg::ST_OK;
			end else if (last_chk) begin
				res_blk_q <= '0;
				res_st_q  <= bba_pkg::ST_FULL;
			end
		end else if (cmd.free_chk) begin
			res_blk_q <= '0;
			res_st_q  <= free_bit ? bba_pkg::ST_OK : bba_pkg::ST_DOUBLE_FREE;
		end
		if (cmd.push) begin
			out_blk_q <= res_blk_q;
			out_st_q  <= res_st_q;
		end
	end

	assign sts.imm_done  = ((action == bba_pkg::ACT_ALLOC) && (lim == '0)) ||
	                       ((action == bba_pkg::ACT_FREE) && ({1'b0, block_number} >= lim));
	assign sts.in_free   = (action == bba_pkg::ACT_FREE);
	assign sts.scan_done = rvld_s1 && (any_free || last_chk);
	assign sts.clr_last  = (clr_ptr_q == LAST_WORD);
	assign sts.out_busy  = rsp_valid_q && rsp_stall;

	assign rsp_valid       = rsp_valid_q;
	assign allocated_block = out_blk_q;
	assign status          = out_st_q;

`ifndef NO_ASSERTIONS
	// clearing, granting and freeing never share the single write port
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, found_we, free_we}))
		else $error("bitmap write port claimed twice");

	// a result is only moved while the output register can take it
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !(rsp_valid_q && rsp_stall))
		else $error("result pushed over a waiting transaction");

	// a nonzero block number only goes out with a successful grant
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (out_blk_q != '0)) |-> (out_st_q == bba_pkg::ST_OK))
		else $error("block number with a failure status");
`endif

endmodule

@@ hdl/block_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// block_bitmap_allocator: first-fit block allocator over a usage bitmap
// One bit per block, held in 64-bit words; allocate grants the lowest free
// block below the configured total, free clears a used block.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. After reset the bitmap is cleared one
// word per cycle, with req_stall high. A free checks and clears its bit in
// the bitmap word, and its result then moves to the output register; an
// allocate reads one 64-bit bitmap word per cycle through the single memory
// read port until it finds a free block or has checked the last word below
// the limit. Out-of-range frees and allocates with a zero total are resolved
// without the bitmap. A finished result waits while a previous result is
// still held in the output register on rsp_stall.
// The next request is taken as soon as the result has moved to the output
// register, even while it waits on rsp_stall.
// cfg_data writes total_blocks; write it only while no request is in flight.
module block_bitmap_allocator #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bba_pkg::TOTAL_W-1:0] cfg_data,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        action,
	input  logic [bba_pkg::BLK_W-1:0]   block_number,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [bba_pkg::BLK_W-1:0]   allocated_block,
	output logic [bba_pkg::STAT_W-1:0]  status
);

	bba_pkg::cmd_t cmd;
	bba_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid),
		.cfg_data        (cfg_data),
		.action          (action),
		.block_number    (block_number),
		.rsp_stall       (rsp_stall),
		.rsp_valid       (rsp_valid),
		.allocated_block (allocated_block),
		.status          (status),
		.cmd             (cmd),
		.sts             (sts)
	);

endmodule
